>>> hdl/cbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SCORE_W   = FRAC_BITS + 1;
  localparam int LABEL_W   = 4;
  localparam int SRC_W     = 2;
  localparam int CFG_IDX_W = 4;

  localparam logic [SCORE_W-1:0] ONE = SCORE_W'(1 << FRAC_BITS);

  localparam logic [SCORE_W-1:0] SCORE_CAP_RESET      = SCORE_W'(64225);
  localparam logic [SCORE_W-1:0] NONIMAGE_RATIO_RESET = SCORE_W'(32768);

  localparam logic [SRC_W-1:0] IMAGE_SOURCE = SRC_W'(1);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_FUSE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_CAP      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NONIMAGE_RATIO = CFG_IDX_W'(1);

  typedef struct packed {
    logic               kind;
    logic [LABEL_W-1:0] detection_label;
    logic [SCORE_W-1:0] detection_score;
    logic [SRC_W-1:0]   sensor_source;
  } det_t;

  typedef struct packed {
    logic [LABEL_W-1:0] fused_label;
    logic [SCORE_W-1:0] fused_score;
    logic               zero_total;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCALE,
    ST_SCALE_SAT,
    ST_SUM_MUL,
    ST_SUM_ACC,
    ST_CHECK,
    ST_DIV_MUL,
    ST_DIV_STEP,
    ST_DIV_ROUND,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hdl/class_belief_fusion_core.sv
// Class belief fusion: keeps one Q1.16 belief mass per object class and
// combines detections into it by the normalized product rule.
// Channels: det (request in, det_valid/det_stall), fused (result out,
// fused_valid/fused_stall), cfg (register writes, cfg_valid/cfg_ready,
// always ready). Each det request yields exactly one fused result.
// A fuse request uses one shared 17x17 multiplier that sweeps the classes
// twice, first to form the product sum, then to recompute each product and
// feed a restoring divider that retires one quotient bit per cycle. A fuse
// whose product sum is zero ends after the first sweep.
// det_stall is high while a request is in work; it drops as the result
// loads into the output register, so the block takes no new request before
// it is through with the last one. If the receiver stalls, that result
// holds and a following result waits inside the block.
// Reset (rst, synchronous) clears all masses to zero, loads the register
// defaults and drops fused_valid.
`timescale 1ns / 1ps
`default_nettype none

module class_belief_fusion_core #(
  parameter int NUM_CLASSES = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           det_valid,
  output logic                                det_stall,
  input  wire cbf_pkg::det_t                  det,
  output logic                                fused_valid,
  input  wire logic                           fused_stall,
  output cbf_pkg::res_t                       fused,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbf_pkg::SCORE_W-1:0]    cfg_data
);

  localparam int SW      = cbf_pkg::SCORE_W;
  localparam int FB      = cbf_pkg::FRAC_BITS;
  localparam int IDX_W   = $clog2(NUM_CLASSES);
  localparam int PROD_W  = 2 * SW;
  localparam int SUM_W   = PROD_W + $clog2(NUM_CLASSES);
  localparam int STEP_W  = $clog2(FB + 1);
  localparam int SCL_W   = PROD_W - FB + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_CLASSES - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FB);
  localparam logic [PROD_W:0]   HALF      = (PROD_W + 1)'(1 << (FB - 1));

  cbf_pkg::state_t state, state_next;

  logic [SW-1:0]     score_cap;
  logic [SW-1:0]     nonimage_ratio;
  logic [SW-1:0]     class_mass [NUM_CLASSES];

  cbf_pkg::det_t     det_q;
  cbf_pkg::res_t     result;
  logic [SW-1:0]     s_q;
  logic [PROD_W-1:0] mul_q;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rem;
  logic [SW-1:0]     quot;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  best_idx;
  logic [SW-1:0]     best_mass;

  logic [SW-1:0]     mass_cur;
  logic              lbl_hit;
  logic [SW-1:0]     vec_cur;
  logic [SW-1:0]     mul_a, mul_b;
  logic [PROD_W:0]   rnd;
  logic [SCL_W-1:0]  s_raw;
  logic [SW-1:0]     s_fuse;
  logic [SW-1:0]     s_min;
  logic [SW-1:0]     s_start;
  logic [SUM_W:0]    trial;
  logic              div_ge;
  logic [SUM_W-1:0]  rem_next;
  logic              round_up;
  logic [SW-1:0]     q_final;
  logic              load_out;
  logic [cbf_pkg::LABEL_W-1:0] start_label;

  assign cfg_ready = 1'b1;
  assign det_stall = (state != cbf_pkg::ST_IDLE);

  // datapath
  always_comb begin
    mass_cur = class_mass[idx];
    lbl_hit  = (int'(det_q.detection_label) == int'(idx));
    vec_cur  = lbl_hit ? cbf_pkg::ONE : cbf_pkg::ONE - s_q;

    if (state == cbf_pkg::ST_SCALE) begin
      mul_a = det_q.detection_score;
      mul_b = nonimage_ratio;
    end else begin
      mul_a = mass_cur;
      mul_b = vec_cur;
    end

    rnd   = {1'b0, mul_q} + HALF;
    s_raw = (det_q.sensor_source == cbf_pkg::IMAGE_SOURCE) ?
            SCL_W'(det_q.detection_score) : rnd[PROD_W:FB];
    s_fuse = (s_raw > SCL_W'(cbf_pkg::ONE)) ? cbf_pkg::ONE : s_raw[SW-1:0];

    s_min   = (det_q.detection_score < score_cap) ? det_q.detection_score : score_cap;
    s_start = (s_min > cbf_pkg::ONE) ? cbf_pkg::ONE : s_min;
    start_label = (int'(det_q.detection_label) < NUM_CLASSES) ?
                  det_q.detection_label : cbf_pkg::LABEL_W'(NUM_CLASSES);

    trial    = (step == '0) ? {1'b0, SUM_W'(mul_q)} : {rem, 1'b0};
    div_ge   = (trial >= {1'b0, sum});
    rem_next = div_ge ? SUM_W'(trial - {1'b0, sum}) : SUM_W'(trial);
    round_up = ({rem, 1'b0} >= {1'b0, sum});
    q_final  = quot + SW'(round_up);

    load_out = (state == cbf_pkg::ST_DONE) && (!fused_valid || !fused_stall);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      cbf_pkg::ST_IDLE: begin
        if (det_valid) begin
          state_next = (det.kind == cbf_pkg::KIND_START) ? cbf_pkg::ST_START
                                                          : cbf_pkg::ST_SCALE;
        end
      end
      cbf_pkg::ST_START:     state_next = cbf_pkg::ST_DONE;
      cbf_pkg::ST_SCALE:     state_next = cbf_pkg::ST_SCALE_SAT;
      cbf_pkg::ST_SCALE_SAT: state_next = cbf_pkg::ST_SUM_MUL;
      cbf_pkg::ST_SUM_MUL:   state_next = cbf_pkg::ST_SUM_ACC;
      cbf_pkg::ST_SUM_ACC: begin
        state_next = (idx == LAST_IDX) ? cbf_pkg::ST_CHECK : cbf_pkg::ST_SUM_MUL;
      end
      cbf_pkg::ST_CHECK: begin
        state_next = (sum == '0) ? cbf_pkg::ST_DONE : cbf_pkg::ST_DIV_MUL;
      end
      cbf_pkg::ST_DIV_MUL:   state_next = cbf_pkg::ST_DIV_STEP;
      cbf_pkg::ST_DIV_STEP: begin
        if (step == LAST_STEP) state_next = cbf_pkg::ST_DIV_ROUND;
      end
      cbf_pkg::ST_DIV_ROUND: begin
        state_next = (idx == LAST_IDX) ? cbf_pkg::ST_FINISH : cbf_pkg::ST_DIV_MUL;
      end
      cbf_pkg::ST_FINISH:    state_next = cbf_pkg::ST_DONE;
      cbf_pkg::ST_DONE: begin
        if (load_out) state_next = cbf_pkg::ST_IDLE;
      end
      default:               state_next = cbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_cap      <= cbf_pkg::SCORE_CAP_RESET;
      nonimage_ratio <= cbf_pkg::NONIMAGE_RATIO_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbf_pkg::REG_SCORE_CAP:      score_cap      <= cfg_data;
        cbf_pkg::REG_NONIMAGE_RATIO: nonimage_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    case (state)
      cbf_pkg::ST_IDLE: begin
        if (det_valid) det_q <= det;
      end
      cbf_pkg::ST_START: begin
        result <= '{fused_label: start_label, fused_score: s_start, zero_total: 1'b0};
      end
      cbf_pkg::ST_SCALE_SAT: begin
        s_q       <= s_fuse;
        idx       <= '0;
        sum       <= '0;
        best_idx  <= '0;
        best_mass <= '0;
      end
      cbf_pkg::ST_SUM_ACC: begin
        sum <= sum + SUM_W'(mul_q);
        if (mass_cur > best_mass) begin
          best_idx  <= idx;
          best_mass <= mass_cur;
        end
        idx <= idx + IDX_W'(1);
      end
      cbf_pkg::ST_CHECK: begin
        result <= '{fused_label: cbf_pkg::LABEL_W'(best_idx), fused_score: best_mass,
                    zero_total: 1'b1};
        idx       <= '0;
        best_idx  <= '0;
        best_mass <= '0;
      end
      cbf_pkg::ST_DIV_MUL: begin
        step <= '0;
      end
      cbf_pkg::ST_DIV_STEP: begin
        rem  <= rem_next;
        quot <= {quot[SW-2:0], div_ge};
        step <= step + STEP_W'(1);
      end
      cbf_pkg::ST_DIV_ROUND: begin
        if (q_final > best_mass) begin
          best_idx  <= idx;
          best_mass <= q_final;
        end
        idx <= idx + IDX_W'(1);
      end
      cbf_pkg::ST_FINISH: begin
        result <= '{fused_label: cbf_pkg::LABEL_W'(best_idx),
                    fused_score: (best_mass >= cbf_pkg::ONE) ? score_cap : best_mass,
                    zero_total: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_mass[i] <= '0;
      end
    end else begin
      case (state)
        cbf_pkg::ST_START: begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            class_mass[i] <= (int'(det_q.detection_label) == i) ? cbf_pkg::ONE
                                                                : cbf_pkg::ONE - s_start;
          end
        end
        cbf_pkg::ST_DIV_ROUND: begin
          class_mass[idx] <= q_final;
        end
        cbf_pkg::ST_FINISH: begin
          if (best_mass >= cbf_pkg::ONE) class_mass[best_idx] <= score_cap;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fused_valid <= 1'b0;
    end else if (load_out) begin
      fused_valid <= 1'b1;
    end else if (!fused_stall) begin
      fused_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) fused <= result;
  end

endmodule

`default_nettype wire

>>> hdl/cbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_checker #(
  parameter int NUM_CLASSES = 12
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          det_valid,
  input wire logic          det_stall,
  input wire logic          fused_valid,
  input wire logic          fused_stall,
  input wire cbf_pkg::res_t fused
);

  // busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    det_valid && !det_stall |=> det_stall)
    else $error("det not stalled after accepting a request");

  // a new result appears only as the block returns to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(fused_valid) |-> !det_stall)
    else $error("result raised while still busy");

  a_zero_label: assert property (@(posedge clk) disable iff (rst)
    fused_valid && fused.zero_total |-> int'(fused.fused_label) < NUM_CLASSES)
    else $error("held-state result names the unknown class");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    fused_valid && fused_stall |=> fused_valid)
    else $error("fused_valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    fused_valid && fused_stall |=> $stable(fused))
    else $error("fused payload changed while stalled");

endmodule

bind class_belief_fusion_core cbf_checker #(.NUM_CLASSES(NUM_CLASSES)) u_cbf_checker (
  .clk         (clk),
  .rst         (rst),
  .det_valid   (det_valid),
  .det_stall   (det_stall),
  .fused_valid (fused_valid),
  .fused_stall (fused_stall),
  .fused       (fused)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cbf_pkg::*;

  localparam int NUM_CLASSES = 12;
  localparam int LABEL_MAX = (1 << LABEL_W) - 1;
  localparam int SCORE_MAX = (1 << SCORE_W) - 1;
  localparam int CFG_IDX_MAX = (1 << CFG_IDX_W) - 1;
  localparam int REG_COUNT = 2;
  localparam logic [LABEL_W-1:0] UNKNOWN_LABEL = LABEL_W'(NUM_CLASSES);
  localparam logic [SRC_W-1:0] RADAR_SOURCE = SRC_W'(0);
  localparam logic [SRC_W-1:0] LIDAR_SOURCE = SRC_W'(2);
  localparam logic [SRC_W-1:0] AUX_SOURCE = SRC_W'(3);
  localparam logic [63:0] HALF_LSB = 64'(ONE) >> 1;
  localparam int TOTAL_ITEMS = 1550;
  localparam int CALM_ITEMS = 150;
  localparam int HOLD_AT = 400;
  localparam int LONG_HOLD = 700;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2500000;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [SCORE_W-1:0]   val;
    det_t                 req;
    logic                 typed;
    res_t                 want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic det_valid = 1'b0;
  logic det_stall;
  det_t det_req = '0;
  logic fused_valid;
  logic fused_stall = 1'b0;
  res_t fused_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCORE_W-1:0] cfg_data = '0;

  logic [SCORE_W-1:0] mass_model [NUM_CLASSES];
  logic [SCORE_W-1:0] cap_setting = SCORE_CAP_RESET;
  logic [SCORE_W-1:0] ratio_setting = NONIMAGE_RATIO_RESET;
  res_t fusion_due [$];
  int mismatches = 0;
  int unsigned cycle_count = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  class_belief_fusion_core uut (
    .clk(clk),
    .rst(rst),
    .det_valid(det_valid),
    .det_stall(det_stall),
    .det(det_req),
    .fused_valid(fused_valid),
    .fused_stall(fused_stall),
    .fused(fused_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic res_t fuse_belief(input det_t d);
    res_t r;
    logic [63:0] s;
    logic [63:0] dvec [NUM_CLASSES];
    logic [63:0] prod [NUM_CLASSES];
    logic [63:0] total;
    logic [63:0] quot;
    logic [63:0] rem;
    int top;
    s = 64'(d.detection_score);
    if (d.kind == KIND_START) begin
      if (s > 64'(cap_setting)) s = 64'(cap_setting);
    end else if (d.sensor_source != IMAGE_SOURCE) begin
      s = (s * 64'(ratio_setting) + HALF_LSB) >> FRAC_BITS;
    end
    if (s > 64'(ONE)) s = 64'(ONE);
    for (int i = 0; i < NUM_CLASSES; i++) dvec[i] = 64'(ONE) - s;
    if (d.detection_label < NUM_CLASSES) dvec[d.detection_label] = 64'(ONE);
    if (d.kind == KIND_START) begin
      for (int i = 0; i < NUM_CLASSES; i++) mass_model[i] = dvec[i][SCORE_W-1:0];
      r.fused_label = (d.detection_label < NUM_CLASSES) ? d.detection_label : UNKNOWN_LABEL;
      r.fused_score = s[SCORE_W-1:0];
      r.zero_total = 1'b0;
      return r;
    end
    total = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      prod[i] = 64'(mass_model[i]) * dvec[i];
      total += prod[i];
    end
    if (total != 0) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        quot = (prod[i] << FRAC_BITS) / total;
        rem = (prod[i] << FRAC_BITS) % total;
        if (2 * rem >= total) quot++;
        mass_model[i] = quot[SCORE_W-1:0];
      end
    end
    top = 0;
    for (int i = 1; i < NUM_CLASSES; i++)
      if (mass_model[i] > mass_model[top]) top = i;
    r.fused_label = LABEL_W'(top);
    r.fused_score = mass_model[top];
    r.zero_total = (total == 0);
    if (total != 0 && mass_model[top] >= ONE) begin
      mass_model[top] = cap_setting;
      r.fused_score = cap_setting;
    end
    return r;
  endfunction

  function automatic plan_row_t ask(input logic kind, input int label, input int score,
                                    input logic [SRC_W-1:0] src);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.val = '0;
    row.req = '{kind, LABEL_W'(label), SCORE_W'(score), src};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t ask_want(input logic kind, input int label, input int score,
                                         input logic [SRC_W-1:0] src, input int flabel,
                                         input int fscore, input logic zt);
    plan_row_t row;
    row = ask(kind, label, score, src);
    row.typed = 1'b1;
    row.want = '{LABEL_W'(flabel), SCORE_W'(fscore), zt};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t row;
    row = ask(KIND_START, 0, 0, RADAR_SOURCE);
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = SCORE_W'(val);
    return row;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_setting();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return ONE;
      default: return SCORE_W'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ONE;
      2: return ONE - 1;
      3: return SCORE_W'($urandom_range(ONE + 1, SCORE_MAX));
      default: return SCORE_W'($urandom_range(0, ONE));
    endcase
  endfunction

  task automatic send_request(input det_t d, input logic typed, input res_t want);
    res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      det_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    det_valid <= 1'b1;
    det_req <= d;
    @(posedge clk);
    while (det_stall) @(posedge clk);
    r = fuse_belief(d);
    fusion_due.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCORE_W-1:0] val);
    if (det_valid) det_valid <= 1'b0;
    while (fusion_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SCORE_CAP) cap_setting = val;
    else if (idx == REG_NONIMAGE_RATIO) ratio_setting = val;
  endtask

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && fused_valid === 1'b1 && !fused_stall) begin
      if (fusion_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual label %0d score %0d zero %0b",
                 $time, fused_res.fused_label, fused_res.fused_score, fused_res.zero_total);
      end else begin
        want = fusion_due.pop_front();
        if (fused_res.fused_label !== want.fused_label)
          flag_field("fused_label", want.fused_label, fused_res.fused_label);
        if (fused_res.fused_score !== want.fused_score)
          flag_field("fused_score", want.fused_score, fused_res.fused_score);
        if (fused_res.zero_total !== want.zero_total)
          flag_field("zero_total", want.zero_total, fused_res.zero_total);
      end
    end
  end

  // result side back-pressure
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        fused_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        fused_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        fused_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        fused_stall <= 1'b0;
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    det_t d;
    int sent;
    int n;
    int track;
    int pick;
    logic hold_used;
    for (int i = 0; i < NUM_CLASSES; i++) mass_model[i] = '0;
    sent = 0;
    hold_used = 1'b0;

    // masses are all zero after reset: a fuse finds an empty product sum
    plan.push_back(ask_want(KIND_FUSE, 3, 40000, IMAGE_SOURCE, 0, 0, 1'b1));
    plan.push_back(ask_want(KIND_START, 0, 0, RADAR_SOURCE, 0, 0, 1'b0));
    plan.push_back(ask_want(KIND_START, 11, ONE, IMAGE_SOURCE, 11, SCORE_CAP_RESET, 1'b0));
    plan.push_back(ask_want(KIND_START, NUM_CLASSES, 1000, LIDAR_SOURCE, NUM_CLASSES, 1000,
                            1'b0));
    plan.push_back(ask_want(KIND_START, LABEL_MAX, SCORE_MAX, AUX_SOURCE, NUM_CLASSES,
                            SCORE_CAP_RESET, 1'b0));
    plan.push_back(ask(KIND_FUSE, 5, ONE, IMAGE_SOURCE));
    plan.push_back(ask(KIND_FUSE, 5, SCORE_MAX, RADAR_SOURCE));
    plan.push_back(reg_row(REG_SCORE_CAP, ONE));
    plan.push_back(reg_row(REG_NONIMAGE_RATIO, ONE));
    plan.push_back(ask_want(KIND_START, 4, ONE, IMAGE_SOURCE, 4, ONE, 1'b0));
    plan.push_back(ask_want(KIND_FUSE, 9, ONE, IMAGE_SOURCE, 4, ONE, 1'b1));
    plan.push_back(ask(KIND_FUSE, 4, ONE, RADAR_SOURCE));
    plan.push_back(ask_want(KIND_START, 14, 70000, LIDAR_SOURCE, NUM_CLASSES, ONE, 1'b0));
    plan.push_back(ask_want(KIND_FUSE, 1, 100, IMAGE_SOURCE, 0, 0, 1'b1));
    plan.push_back(reg_row(REG_SCORE_CAP, 0));
    plan.push_back(reg_row(REG_NONIMAGE_RATIO, 0));
    plan.push_back(ask_want(KIND_START, 6, 50000, RADAR_SOURCE, 6, 0, 1'b0));
    plan.push_back(ask(KIND_FUSE, 6, 40000, LIDAR_SOURCE));
    plan.push_back(ask(KIND_FUSE, 8, ONE - 1, IMAGE_SOURCE));
    plan.push_back(ask(KIND_FUSE, NUM_CLASSES, 30000, AUX_SOURCE));
    plan.push_back(reg_row(REG_SCORE_CAP, SCORE_CAP_RESET));
    plan.push_back(reg_row(REG_NONIMAGE_RATIO, NONIMAGE_RATIO_RESET));
    plan.push_back(ask_want(KIND_START, 2, 30000, RADAR_SOURCE, 2, 30000, 1'b0));
    plan.push_back(ask(KIND_FUSE, 2, 50000, AUX_SOURCE));
    plan.push_back(ask(KIND_FUSE, 7, 60000, IMAGE_SOURCE));
    plan.push_back(ask(KIND_FUSE, 13, 20000, LIDAR_SOURCE));
    plan.push_back(ask(KIND_FUSE, 3, ONE - 1, RADAR_SOURCE));
    // unused register index must leave the cap alone
    plan.push_back(reg_row(CFG_IDX_W'(CFG_IDX_MAX), SCORE_MAX));
    plan.push_back(ask_want(KIND_START, 0, ONE, IMAGE_SOURCE, 0, SCORE_CAP_RESET, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        write_reg(plan[k].idx, plan[k].val);
        if (k + 1 == plan.size() || !plan[k + 1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_request(plan[k].req, plan[k].typed, plan[k].want);
        sent++;
      end
    end

    while (sent < TOTAL_ITEMS) begin
      if (!calm) begin
        if ($urandom_range(0, 2) != 0) write_reg(REG_SCORE_CAP, pick_setting());
        if ($urandom_range(0, 2) != 0) write_reg(REG_NONIMAGE_RATIO, pick_setting());
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, CFG_IDX_MAX)),
                    SCORE_W'($urandom_range(0, SCORE_MAX)));
      end
      if (cfg_valid) cfg_valid <= 1'b0;
      n = $urandom_range(10, 60);
      track = $urandom_range(0, NUM_CLASSES - 1);
      for (int j = 0; j < n && sent < TOTAL_ITEMS; j++) begin
        if (j == 0) d.kind = ($urandom_range(0, 9) != 0) ? KIND_START : KIND_FUSE;
        else d.kind = ($urandom_range(0, 7) == 0) ? KIND_START : KIND_FUSE;
        pick = $urandom_range(0, 9);
        if (pick < 5) d.detection_label = LABEL_W'(track);
        else if (pick < 8) d.detection_label = LABEL_W'($urandom_range(0, NUM_CLASSES - 1));
        else d.detection_label = LABEL_W'($urandom_range(NUM_CLASSES, LABEL_MAX));
        if (d.kind == KIND_START && d.detection_label < NUM_CLASSES)
          track = d.detection_label;
        d.detection_score = pick_score();
        d.sensor_source = $urandom_range(0, 1) ? IMAGE_SOURCE : SRC_W'($urandom_range(0, 3));
        send_request(d, 1'b0, '0);
        sent++;
        // keep offering requests through the hold so the block fills up
        if (!hold_used && sent >= HOLD_AT && j + 2 < n) begin
          hold_used = 1'b1;
          hold_req = 1'b1;
        end
        if (sent >= TOTAL_ITEMS - CALM_ITEMS) calm = 1'b1;
      end
    end

    det_valid <= 1'b0;
    while (fusion_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
